// ----- hw/rtl/acws_pkg.sv -----
// Shared types and constants for the converter channel window statistics block.
package acws_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int SAMPLE_BITS  = 12;
    localparam int MAX_WINDOW   = 1024;

    localparam int CH_BITS    = 5;
    localparam int WIN_BITS   = 11;
    localparam int CNT_BITS   = 6;
    localparam int ROUND_BITS = 10;
    localparam int RES_BITS   = 16;
    localparam int SUM_BITS   = SAMPLE_BITS + 10;
    localparam int SQ_BITS    = 2 * SAMPLE_BITS + 10;
    localparam int MEAN_BITS  = SUM_BITS + 4;
    localparam int DIV_BITS   = SQ_BITS + 8;
    localparam int REM_BITS   = WIN_BITS + 1;
    localparam int ROOT_STEPS = DIV_BITS / 2;
    localparam int STEP_BITS  = $clog2(DIV_BITS + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET  = 11'd16;
    localparam logic [CNT_BITS-1:0] CHANNEL_RESET = 6'd26;

    typedef enum logic {
        CFG_WINDOW_COUNT  = 1'b0,
        CFG_CHANNEL_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        logic [11:0]        sample_value;
    } sample_t;

    typedef struct packed {
        logic [CH_BITS-1:0]  out_channel;
        logic [RES_BITS-1:0] mean_q4;
        logic [RES_BITS-1:0] stddev_q4;
        logic [11:0]         min_value;
        logic [11:0]         max_value;
    } stats_t;

    typedef struct packed {
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] value;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_UPD,
        B_DIV,
        B_MUL,
        B_SUB,
        B_SQRT,
        B_OUT
    } back_state_t;

endpackage

// ----- hw/rtl/adc_channel_window_statistics.sv -----
// Converter channel window statistics: top level.
// In the engine, a sample that does not close a window passes through load and update;
//   one that closes a window also goes through the 42-step divider, multiply, subtract,
//   21-step root and result load, and the result load waits for the receiver.
// The engine takes its next sample from the queue only once it is back in idle.
// A 4-deep queue lets the front end keep taking samples while the engine works.
// Reset (rst_n low, asynchronous) empties the queue, clears all channel stores
//   through their used bits, zeroes the round and loads window 16, channels 26.
module adc_channel_window_statistics
    import acws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_index_t          cfg_index,
    input  logic [WIN_BITS-1:0] cfg_data,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  sample_t             sample,
    output logic                stats_valid,
    input  logic                stats_ready,
    output stats_t              stats
);

    // front end to queue
    logic                push;
    job_t                push_job;
    logic [WIN_BITS-1:0] win;

    // queue to engine
    logic          pop;
    job_t          head;
    queue_status_t q_status;

    // Filter out-of-range channels, track rounds, tag the closing round.
    acws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_status     (q_status),
        .push         (push),
        .job          (push_job),
        .win          (win)
    );

    // Hold accepted requests until the engine frees up.
    acws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Accumulate per channel; on the closing round divide, take the root, emit.
    acws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .win         (win),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .stats_valid (stats_valid),
        .stats_ready (stats_ready),
        .stats       (stats)
    );

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid |-> (stats.min_value <= stats.max_value))
        else $error("reported minimum above maximum");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("engine popped an empty queue");

endmodule

// ----- hw/rtl/acws_front.sv -----
// Front end: configuration registers, channel filter and round tracking.
module acws_front
    import acws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_index_t          cfg_index,
    input  logic [WIN_BITS-1:0] cfg_data,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  sample_t             sample,
    input  queue_status_t       q_status,
    output logic                push,
    output job_t                job,
    output logic [WIN_BITS-1:0] win
);

    logic [WIN_BITS-1:0]   window_count_reg;
    logic [CNT_BITS-1:0]   channel_count_reg;
    logic [ROUND_BITS-1:0] round_reg, round_next;
    logic [CNT_BITS-1:0]   nch;
    logic                  in_range, last, closes;

    assign cfg_ready    = 1'b1;
    assign sample_ready = !q_status.full;

    always_comb
    begin
        nch = (channel_count_reg > CNT_BITS'(MAX_CHANNELS)) ?
              CNT_BITS'(MAX_CHANNELS) : channel_count_reg;
        if (window_count_reg == '0)
            win = WIN_BITS'(1);
        else if (window_count_reg > WIN_BITS'(MAX_WINDOW))
            win = WIN_BITS'(MAX_WINDOW);
        else
            win = window_count_reg;
        in_range = {1'b0, sample.channel} < nch;
        last     = ({1'b0, round_reg} + WIN_BITS'(1)) >= win;
        closes   = {1'b0, sample.channel} == (nch - CNT_BITS'(1));
        push     = sample_valid && sample_ready && in_range;
        job.channel = sample.channel;
        job.value   = sample.sample_value[SAMPLE_BITS-1:0];
        job.last    = last;
        round_next  = round_reg;
        if (push && closes)
            round_next = last ? '0 : round_reg + ROUND_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg  <= WINDOW_RESET;
            channel_count_reg <= CHANNEL_RESET;
            round_reg         <= '0;
        end
        else
        begin
            round_reg <= round_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WINDOW_COUNT)
                    window_count_reg <= cfg_data;
                else
                    channel_count_reg <= cfg_data[CNT_BITS-1:0];
            end
        end
    end

endmodule

// ----- hw/rtl/acws_queue.sv -----
// Short request queue between the front end and the statistics engine.
module acws_queue
    import acws_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t status
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [PTR_BITS:0]   count_reg;

    assign status.full  = count_reg == (PTR_BITS+1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head         = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + PTR_BITS'(1);
            if (pop)
                rd_reg <= rd_reg + PTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_BITS+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_BITS+1)'(1);
        end
    end

endmodule

// ----- hw/rtl/acws_back.sv -----
// Statistics engine: channel stores, serial divider, serial root, result register.
module acws_back
    import acws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WIN_BITS-1:0] win,
    input  queue_status_t       q_status,
    input  job_t                head,
    output logic                pop,
    output logic                stats_valid,
    input  logic                stats_ready,
    output stats_t              stats
);

    back_state_t state_reg, state_next;

    logic [SUM_BITS-1:0]    sum_mem [MAX_CHANNELS];
    logic [SQ_BITS-1:0]     sq_mem  [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] min_mem [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] max_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] used_reg;

    job_t                     job_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    logic [SAMPLE_BITS-1:0]   min_w_reg, max_w_reg;
    logic [DIV_BITS-1:0]      dq_a_reg, dq_b_reg;
    logic [REM_BITS-1:0]      rem_a_reg, rem_b_reg;
    logic [STEP_BITS-1:0]     cnt_reg;
    logic [2*MEAN_BITS-1:0]   m2_reg;
    logic [DIV_BITS-1:0]      x_reg, root_reg, bit_reg;
    logic                     stats_valid_reg;
    stats_t                   stats_reg;

    logic store_we, clear, load_out;
    logic [SUM_BITS-1:0]    cur_sum, sum_new;
    logic [SQ_BITS-1:0]     cur_sq, sq_new;
    logic [SAMPLE_BITS-1:0] cur_min, cur_max, min_new, max_new;
    logic [SUM_BITS:0]      sum_wide;
    logic [SQ_BITS:0]       sq_wide;
    logic [REM_BITS-1:0]    rem_sh_a, rem_sh_b, win_ext;
    logic                   ge_a, ge_b;
    logic [MEAN_BITS-1:0]   mean;
    logic [2*MEAN_BITS-1:0] msq_wide;
    logic [DIV_BITS-1:0]    trial;

    assign stats_valid = stats_valid_reg;
    assign stats       = stats_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_status.empty) state_next = B_LOAD;
            B_LOAD: state_next = B_UPD;
            B_UPD:  state_next = job_reg.last ? B_DIV : B_IDLE;
            B_DIV:  if (cnt_reg == STEP_BITS'(DIV_BITS - 1)) state_next = B_MUL;
            B_MUL:  state_next = B_SUB;
            B_SUB:  state_next = B_SQRT;
            B_SQRT: if (cnt_reg == STEP_BITS'(ROOT_STEPS - 1)) state_next = B_OUT;
            B_OUT:  if (!stats_valid_reg || stats_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop      = (state_reg == B_IDLE) && !q_status.empty;
        store_we = (state_reg == B_UPD) && !job_reg.last;
        clear    = (state_reg == B_UPD) && job_reg.last;
        load_out = (state_reg == B_OUT) && (!stats_valid_reg || stats_ready);
    end

    // datapath
    always_comb
    begin
        cur_sum  = used_reg[job_reg.channel] ? sum_mem[job_reg.channel] : '0;
        cur_sq   = used_reg[job_reg.channel] ? sq_mem[job_reg.channel]  : '0;
        cur_min  = used_reg[job_reg.channel] ? min_mem[job_reg.channel] : '1;
        cur_max  = used_reg[job_reg.channel] ? max_mem[job_reg.channel] : '0;
        sum_wide = {1'b0, cur_sum} + (SUM_BITS+1)'(job_reg.value);
        sq_wide  = {1'b0, cur_sq} + (SQ_BITS+1)'(sq_reg);
        sum_new  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
        sq_new   = sq_wide[SQ_BITS] ? '1 : sq_wide[SQ_BITS-1:0];
        min_new  = (job_reg.value < cur_min) ? job_reg.value : cur_min;
        max_new  = (job_reg.value > cur_max) ? job_reg.value : cur_max;

        win_ext  = {1'b0, win};
        rem_sh_a = {rem_a_reg[REM_BITS-2:0], dq_a_reg[DIV_BITS-1]};
        rem_sh_b = {rem_b_reg[REM_BITS-2:0], dq_b_reg[DIV_BITS-1]};
        ge_a     = rem_sh_a >= win_ext;
        ge_b     = rem_sh_b >= win_ext;

        mean     = dq_a_reg[MEAN_BITS-1:0];
        msq_wide = (2*MEAN_BITS)'(dq_b_reg);
        trial    = root_reg + bit_reg;
    end

    // channel stores, no reset: used bits stand for the cleared value
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            sum_mem[job_reg.channel] <= sum_new;
            sq_mem[job_reg.channel]  <= sq_new;
            min_mem[job_reg.channel] <= min_new;
            max_mem[job_reg.channel] <= max_new;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                    job_reg <= head;
            end
            B_LOAD:
            begin
                sq_reg <= job_reg.value * job_reg.value;
            end
            B_UPD:
            begin
                min_w_reg <= min_new;
                max_w_reg <= max_new;
                dq_a_reg  <= DIV_BITS'({sum_new, 4'b0});
                dq_b_reg  <= {sq_new, 8'b0};
                rem_a_reg <= '0;
                rem_b_reg <= '0;
            end
            B_DIV:
            begin
                rem_a_reg <= ge_a ? rem_sh_a - win_ext : rem_sh_a;
                rem_b_reg <= ge_b ? rem_sh_b - win_ext : rem_sh_b;
                dq_a_reg  <= {dq_a_reg[DIV_BITS-2:0], ge_a};
                dq_b_reg  <= {dq_b_reg[DIV_BITS-2:0], ge_b};
            end
            B_MUL:
            begin
                m2_reg <= mean * mean;
            end
            B_SUB:
            begin
                x_reg    <= (msq_wide > m2_reg) ? DIV_BITS'(msq_wide - m2_reg) : '0;
                root_reg <= '0;
                bit_reg  <= DIV_BITS'(1) << (DIV_BITS - 2);
            end
            B_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg    <= x_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_OUT:
            begin
                if (load_out)
                begin
                    stats_reg.out_channel <= job_reg.channel;
                    stats_reg.mean_q4     <= (mean > MEAN_BITS'(16'hFFFF)) ?
                                             '1 : mean[RES_BITS-1:0];
                    stats_reg.stddev_q4   <= (root_reg > DIV_BITS'(16'hFFFF)) ?
                                             '1 : root_reg[RES_BITS-1:0];
                    stats_reg.min_value   <= 12'(min_w_reg);
                    stats_reg.max_value   <= 12'(max_w_reg);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            used_reg        <= '0;
            cnt_reg         <= '0;
            stats_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_we)
                used_reg[job_reg.channel] <= 1'b1;
            if (clear)
                used_reg[job_reg.channel] <= 1'b0;
            if (state_reg == B_DIV || state_reg == B_SQRT)
                cnt_reg <= (state_next == state_reg) ? cnt_reg + STEP_BITS'(1) : '0;
            else
                cnt_reg <= '0;
            if (load_out)
                stats_valid_reg <= 1'b1;
            else if (stats_ready)
                stats_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- test/tb_acws_checker.sv -----
`timescale 1ns / 1ps
// Checker for the channel window statistics block: predicts results and compares them.
module tb_acws_checker
    import acws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [WIN_BITS-1:0] cfg_data,
    input  logic       sample_valid,
    input  logic       sample_ready,
    input  sample_t    sample,
    input  logic       stats_valid,
    input  logic       stats_ready,
    input  stats_t     stats,
    output int         fail_count,
    output int         pending_count
);

    logic [WIN_BITS-1:0] window_reg;
    logic [CNT_BITS-1:0] channel_reg;
    logic [SUM_BITS-1:0] sum_acc [MAX_CHANNELS];
    logic [SQ_BITS-1:0]  square_acc [MAX_CHANNELS];
    logic [11:0]         min_acc [MAX_CHANNELS];
    logic [11:0]         max_acc [MAX_CHANNELS];
    logic [ROUND_BITS-1:0] round_cnt;
    stats_t              stats_expected [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic clear_channel(input int c);
        sum_acc[c] = '0;
        square_acc[c] = '0;
        min_acc[c] = '1;
        max_acc[c] = '0;
    endtask

    task automatic predict_sample(input sample_t s);
        logic [63:0] nch;
        logic [63:0] win;
        logic [63:0] acc;
        logic [63:0] mean;
        logic [63:0] msq;
        logic [63:0] m2;
        logic [63:0] sd;
        logic        last_round;
        int          c;
        stats_t      r;
        nch = (channel_reg > MAX_CHANNELS) ? MAX_CHANNELS : channel_reg;
        win = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
        if (s.channel >= nch)
            return;
        c = s.channel;
        acc = 64'(sum_acc[c]) + s.sample_value;
        sum_acc[c] = (acc > {SUM_BITS{1'b1}}) ? '1 : acc[SUM_BITS-1:0];
        acc = 64'(square_acc[c]) + 64'(s.sample_value) * s.sample_value;
        square_acc[c] = (acc > {SQ_BITS{1'b1}}) ? '1 : acc[SQ_BITS-1:0];
        if (s.sample_value > max_acc[c])
            max_acc[c] = s.sample_value;
        if (s.sample_value < min_acc[c])
            min_acc[c] = s.sample_value;
        last_round = (64'(round_cnt) + 1 >= win);
        if (last_round)
        begin
            mean = (64'(sum_acc[c]) * 16) / win;
            msq = (64'(square_acc[c]) * 256) / win;
            m2 = mean * mean;
            sd = int_sqrt((msq > m2) ? msq - m2 : 0);
            r.out_channel = s.channel;
            r.mean_q4 = (mean > 16'hFFFF) ? 16'hFFFF : mean[15:0];
            r.stddev_q4 = (sd > 16'hFFFF) ? 16'hFFFF : sd[15:0];
            r.min_value = min_acc[c];
            r.max_value = max_acc[c];
            stats_expected.push_back(r);
            clear_channel(c);
        end
        if (s.channel == nch - 1)
            round_cnt = last_round ? '0 : round_cnt + 1'b1;
    endtask

    task automatic check_result(input stats_t got);
        stats_t want;
        if (stats_expected.size() == 0)
        begin
            report("unexpected result, channel", got.out_channel, 0);
            return;
        end
        want = stats_expected.pop_front();
        if (got.out_channel != want.out_channel)
            report("out_channel", got.out_channel, want.out_channel);
        if (got.mean_q4 != want.mean_q4)
            report("mean_q4", got.mean_q4, want.mean_q4);
        if (got.stddev_q4 != want.stddev_q4)
            report("stddev_q4", got.stddev_q4, want.stddev_q4);
        if (got.min_value != want.min_value)
            report("min_value", got.min_value, want.min_value);
        if (got.max_value != want.max_value)
            report("max_value", got.max_value, want.max_value);
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending_count = stats_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            channel_reg = CHANNEL_RESET;
            round_cnt = '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
                clear_channel(c);
            stats_expected.delete();
        end
        else
        begin
            if (stats_valid && stats_ready)
                check_result(stats);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WINDOW_COUNT)
                    window_reg = cfg_data;
                else
                    channel_reg = cfg_data[CNT_BITS-1:0];
            end
            if (sample_valid && sample_ready)
                predict_sample(sample);
        end
    end

endmodule

// ----- test/tb_adc_channel_window_statistics.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus, configuration phases and verdict for window statistics.
module tb_adc_channel_window_statistics;
    import acws_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_index_t          cfg_index;
    logic [WIN_BITS-1:0] cfg_data;
    logic                sample_valid;
    logic                sample_ready;
    sample_t             sample;
    logic                stats_valid;
    logic                stats_ready;
    stats_t              stats;
    int                  fail_count;
    int                  pending_count;
    int                  idle_cycles;
    logic                hold_off;

    // Current channel count as the stimulus sees it; shapes well-formed rounds.
    int                  cur_channels;

    adc_channel_window_statistics DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .stats_valid  (stats_valid),
        .stats_ready  (stats_ready),
        .stats        (stats)
    );

    tb_acws_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .stats_valid   (stats_valid),
        .stats_ready   (stats_ready),
        .stats         (stats),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Send one sample request after a random gap; hold it until accepted.
    task automatic send_sample(input logic [4:0] ch, input logic [11:0] value);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{channel: ch, sample_value: value};
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // Write one register; block is idle here.
    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[WIN_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Wait until all results are in, plus engine latency for samples without results.
    task automatic drain;
        sample_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int win, input int chans);
        drain();
        write_reg(CFG_WINDOW_COUNT, win);
        write_reg(CFG_CHANNEL_COUNT, chans);
        cfg_valid <= 1'b0;
        cur_channels = (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
    endtask

    // Random value biased toward the extremes so every bit toggles and saturates.
    function automatic logic [11:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    // One well-formed round with random content; occasionally a skip, repeat or stray.
    task automatic send_round(input bit noisy);
        for (int c = 0; c < cur_channels; c++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_sample(5'($urandom), pick_value());
            else
                send_sample(5'(c), pick_value());
        end
    endtask

    // Receiver: random stall per result, with one long hold-off on request.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        stats_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                stats_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
                stats_ready <= 1'b1;
            else if (stats_valid && stats_ready)
                stats_ready <= 1'b0;
            else if (!stats_ready)
            begin
                repeat ($urandom_range(0, 11)) @(posedge clk);
                stats_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any accepted request.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready)
            || (stats_valid && stats_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[adc_channel_window_statistics] ERROR");
            $finish;
        end
    end

    initial
    begin
        int limit;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_COUNT;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        hold_off = 1'b0;
        cur_channels = 26;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: window of one, every sample reports; extremes and strays.
        set_config(1, 4);
        send_sample(5'd0, 12'h000);
        send_sample(5'd1, 12'hFFF);
        send_sample(5'd2, 12'hAAA);
        send_sample(5'd3, 12'h555);
        send_sample(5'd31, 12'h123);    // out of range, ignored
        send_sample(5'd2, 12'h001);     // repeat
        send_sample(5'd0, 12'h7FF);     // out of order
        send_sample(5'd3, 12'h800);
        // Window zero acts as one; oversized window saturates; channel count zero ignores.
        set_config(0, 0);
        send_sample(5'd0, 12'hFFF);
        send_sample(5'd5, 12'h010);
        set_config(2047, 40);
        for (int i = 0; i < 6; i++)
            send_sample(5'(i), 12'hFFF);
        set_config(2, 2);
        for (int i = 0; i < 4; i++)
            send_sample(5'(i % 2), (i < 2) ? 12'hFFF : 12'h000);
        // Shrink the window mid-window.
        set_config(4, 1);
        send_sample(5'd0, 12'h100);
        send_sample(5'd0, 12'h200);
        set_config(1, 1);
        send_sample(5'd0, 12'h300);

        // Long hold-off while samples keep coming: window one, every sample reports.
        set_config(1, 32);
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(5'(i % 32), pick_value());

        // Random phases.
        for (int phase = 0; phase < 10; phase++)
        begin
            int w;
            int n;
            int rounds;
            case (phase % 4)
                0: w = $urandom_range(1, 4);
                1: w = $urandom_range(0, 8);
                2: w = 1;
                default: w = $urandom_range(2, 3);
            endcase
            case (phase % 3)
                0: n = $urandom_range(1, 6);
                1: n = 32;
                default: n = $urandom_range(1, 63);
            endcase
            set_config(w, n);
            limit = 90 / ((cur_channels == 0) ? 1 : cur_channels) + 1;
            rounds = limit;
            for (int r = 0; r < rounds; r++)
                send_round(phase % 2);
        end
        // Long window once with a single channel.
        set_config(200, 1);
        for (int i = 0; i < 200; i++)
            send_sample(5'd0, (i % 2) ? 12'hFFF : 12'($urandom));

        drain();
        if (fail_count == 0)
            $display("[adc_channel_window_statistics] OK");
        else
            $display("[adc_channel_window_statistics] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/acws_pkg.sv
hw/rtl/acws_front.sv
hw/rtl/acws_queue.sv
hw/rtl/acws_back.sv
hw/rtl/adc_channel_window_statistics.sv
test/tb_acws_checker.sv
test/tb_adc_channel_window_statistics.sv
